// ----- rtl/ufc_pkg.sv -----
// Shared types and constants for the UDP port frame classifier.
package ufc_pkg;

    // Verdict codes
    localparam logic [2:0] VERDICT_NONE     = 3'd0;
    localparam logic [2:0] VERDICT_ACCEPT   = 3'd1;
    localparam logic [2:0] VERDICT_LENDROP  = 3'd2;
    localparam logic [2:0] VERDICT_NULLSINK = 3'd3;
    localparam logic [2:0] VERDICT_FULL     = 3'd4;

    // Configuration register indexes
    localparam int unsigned CFG_INDEX_W = 8;
    localparam logic [CFG_INDEX_W-1:0] REG_CLAIM_PORT   = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_PAYLOAD  = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_PAYLOAD  = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_DISCARD_MODE = 8'd3;

    localparam logic [15:0] RST_MAX_PAYLOAD = 16'd1500;

    // Frame layout
    localparam logic [15:0] POS_ETHTYPE_HI = 16'd12;
    localparam logic [15:0] POS_ETHTYPE_LO = 16'd13;
    localparam logic [15:0] POS_IP_VER_IHL = 16'd14;
    localparam logic [15:0] POS_IP_PROTO   = 16'd23;
    localparam logic [15:0] POS_MAX        = 16'hFFFF;

    localparam logic [7:0]  ETHTYPE_IPV4_HI = 8'h08;
    localparam logic [7:0]  ETHTYPE_IPV4_LO = 8'h00;
    localparam logic [7:0]  PROTO_UDP       = 8'd17;
    localparam logic [3:0]  IP_VERSION4     = 4'd4;

    localparam logic [6:0]  ETH_HDR_LEN     = 7'd14;
    localparam logic [6:0]  UDP_HDR_LEN     = 7'd8;
    localparam logic [5:0]  MIN_IHL_BYTES   = 6'd20;
    localparam logic [15:0] MIN_FRAME_LEN   = 16'd42;
    localparam logic [15:0] MIN_UDP_LEN     = 16'd8;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
        logic       sink_full;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  verdict;
        logic [6:0]  payload_offset;
        logic [15:0] payload_length;
    } t_out_item;

    typedef struct packed {
        logic [15:0] claim_port;
        logic [15:0] min_payload;
        logic [15:0] max_payload;
        logic        discard_mode;
    } t_cfg;

    // Header fields as seen after the current byte is captured
    typedef struct packed {
        logic [15:0] frame_len;
        logic        ethertype_ok;
        logic [3:0]  version_field;
        logic [3:0]  header_words;
        logic        protocol_ok;
        logic [15:0] dest_port;
        logic [15:0] udp_length;
    } t_frame_info;

endpackage

// ----- rtl/udp_port_frame_classifier_unit.sv -----
// Top level: input register, capture, verdict, result register, config regs.
// Throughput: one frame byte accepted per cycle, sustained, with the result
// register free or being taken; bytes that are not final never wait on it.
// Path: the final byte goes through the input register, then the capture and
// claim logic into the result register, which drives o_out_valid.
// Reset (synchronous, active low) clears the frame state, empties both
// registers and restores claim port 0, min 0, max 1500, discard off.
module udp_port_frame_classifier_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  ufc_pkg::t_in_item                   i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output ufc_pkg::t_out_item                  o_out_data,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ufc_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [15:0]                         i_cfg_data
);

    ufc_pkg::t_cfg        r_cfg;
    logic                 r_in_valid;
    ufc_pkg::t_in_item    r_in_item;
    logic                 r_out_valid;
    ufc_pkg::t_out_item   r_out_item;

    ufc_pkg::t_frame_info w_info;
    ufc_pkg::t_out_item   w_result;
    logic                 w_out_free;
    logic                 w_advance;
    logic                 w_emit;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_advance   = r_in_valid && (!r_in_item.last_byte || w_out_free);
    assign w_emit      = w_advance && r_in_item.last_byte;
    assign o_in_ready  = !r_in_valid || w_advance;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.claim_port   <= '0;
            r_cfg.min_payload  <= '0;
            r_cfg.max_payload  <= ufc_pkg::RST_MAX_PAYLOAD;
            r_cfg.discard_mode <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                ufc_pkg::REG_CLAIM_PORT:   r_cfg.claim_port   <= i_cfg_data;
                ufc_pkg::REG_MIN_PAYLOAD:  r_cfg.min_payload  <= i_cfg_data;
                ufc_pkg::REG_MAX_PAYLOAD:  r_cfg.max_payload  <= i_cfg_data;
                ufc_pkg::REG_DISCARD_MODE: r_cfg.discard_mode <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_item <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_item <= w_result;
        end
    end

    ufc_capture u_capture (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_advance),
        .i_byte  (r_in_item.data_byte),
        .i_last  (r_in_item.last_byte),
        .o_info  (w_info)
    );

    ufc_verdict u_verdict (
        .i_info      (w_info),
        .i_cfg       (r_cfg),
        .i_sink_full (r_in_item.sink_full),
        .o_result    (w_result)
    );

`ifndef SYNTHESIS
    // A pending result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !w_emit)
        else $error("result register overwritten while stalled");

    // A result appears only after a final byte went through
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(w_emit))
        else $error("result without a final byte");

    // Unclaimed frames carry zero offset and length
    a_unclaimed_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_item.verdict == ufc_pkg::VERDICT_NONE)
        |-> (r_out_item.payload_offset == 7'd0 && r_out_item.payload_length == 16'd0))
        else $error("unclaimed frame with nonzero offset or length");

    // Claimed frames have at least a minimal IPv4 plus UDP header in front
    a_claimed_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_item.verdict != ufc_pkg::VERDICT_NONE)
        |-> (r_out_item.payload_offset >= 7'd42))
        else $error("claimed frame with short payload offset");
`endif

endmodule

// ----- rtl/ufc_capture.sv -----
// Byte position tracking and header field capture for one frame.
module ufc_capture (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic [7:0]           i_byte,
    input  logic                 i_last,
    output ufc_pkg::t_frame_info o_info
);

    logic [15:0] r_pos;
    logic        r_eth;
    logic [3:0]  r_ver;
    logic [3:0]  r_hw;
    logic        r_proto;
    logic [15:0] r_dport;
    logic [15:0] r_ulen;

    logic        n_eth;
    logic [3:0]  n_ver;
    logic [3:0]  n_hw;
    logic        n_proto;
    logic [15:0] n_dport;
    logic [15:0] n_ulen;
    logic [15:0] n_pos;

    logic [6:0]  w_udp_base;
    logic [15:0] w_base16;

    assign w_udp_base = ufc_pkg::ETH_HDR_LEN + {1'b0, r_hw, 2'b00};
    assign w_base16   = {9'd0, w_udp_base};
    assign n_pos      = (r_pos == ufc_pkg::POS_MAX) ? r_pos : r_pos + 16'd1;

    always_comb begin
        n_eth   = r_eth;
        n_ver   = r_ver;
        n_hw    = r_hw;
        n_proto = r_proto;
        n_dport = r_dport;
        n_ulen  = r_ulen;
        if (r_pos == ufc_pkg::POS_ETHTYPE_HI) begin
            n_eth = (i_byte == ufc_pkg::ETHTYPE_IPV4_HI);
        end
        if (r_pos == ufc_pkg::POS_ETHTYPE_LO) begin
            n_eth = r_eth && (i_byte == ufc_pkg::ETHTYPE_IPV4_LO);
        end
        if (r_pos == ufc_pkg::POS_IP_VER_IHL) begin
            n_ver = i_byte[7:4];
            n_hw  = i_byte[3:0];
        end
        if (r_pos == ufc_pkg::POS_IP_PROTO) begin
            n_proto = (i_byte == ufc_pkg::PROTO_UDP);
        end
        // UDP offsets follow the IHL captured earlier in this frame
        if (r_pos == w_base16 + 16'd2) begin
            n_dport[15:8] = i_byte;
        end
        if (r_pos == w_base16 + 16'd3) begin
            n_dport[7:0] = i_byte;
        end
        if (r_pos == w_base16 + 16'd4) begin
            n_ulen[15:8] = i_byte;
        end
        if (r_pos == w_base16 + 16'd5) begin
            n_ulen[7:0] = i_byte;
        end
    end

    assign o_info.frame_len     = n_pos;
    assign o_info.ethertype_ok  = n_eth;
    assign o_info.version_field = n_ver;
    assign o_info.header_words  = n_hw;
    assign o_info.protocol_ok   = n_proto;
    assign o_info.dest_port     = n_dport;
    assign o_info.udp_length    = n_ulen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_last)) begin
            r_pos   <= '0;
            r_eth   <= 1'b0;
            r_ver   <= '0;
            r_hw    <= '0;
            r_proto <= 1'b0;
            r_dport <= '0;
            r_ulen  <= '0;
        end else if (i_step) begin
            r_pos   <= n_pos;
            r_eth   <= n_eth;
            r_ver   <= n_ver;
            r_hw    <= n_hw;
            r_proto <= n_proto;
            r_dport <= n_dport;
            r_ulen  <= n_ulen;
        end
    end

endmodule

// ----- rtl/ufc_verdict.sv -----
// Claim test and verdict selection on the final byte of a frame.
module ufc_verdict (
    input  ufc_pkg::t_frame_info i_info,
    input  ufc_pkg::t_cfg        i_cfg,
    input  logic                 i_sink_full,
    output ufc_pkg::t_out_item   o_result
);

    logic [5:0]  w_ihl_bytes;
    logic [6:0]  w_hdr_end;
    logic [6:0]  w_offset;
    logic [15:0] w_plen;
    logic [16:0] w_udp_end;
    logic        w_claimed;

    assign w_ihl_bytes = {i_info.header_words, 2'b00};
    assign w_hdr_end   = ufc_pkg::ETH_HDR_LEN + {1'b0, w_ihl_bytes};
    assign w_offset    = w_hdr_end + ufc_pkg::UDP_HDR_LEN;
    assign w_plen      = i_info.udp_length - 16'd8;
    assign w_udp_end   = {1'b0, i_info.udp_length} + {10'd0, w_hdr_end};

    assign w_claimed = (i_cfg.claim_port != 16'd0)
        && (i_info.frame_len >= ufc_pkg::MIN_FRAME_LEN)
        && i_info.ethertype_ok
        && (i_info.version_field == ufc_pkg::IP_VERSION4)
        && (w_ihl_bytes >= ufc_pkg::MIN_IHL_BYTES)
        && (i_info.frame_len >= {9'd0, w_offset})
        && i_info.protocol_ok
        && (i_info.dest_port == i_cfg.claim_port)
        && (i_info.udp_length >= ufc_pkg::MIN_UDP_LEN)
        && (w_udp_end <= {1'b0, i_info.frame_len});

    always_comb begin
        o_result.verdict        = ufc_pkg::VERDICT_NONE;
        o_result.payload_offset = '0;
        o_result.payload_length = '0;
        if (w_claimed) begin
            o_result.payload_offset = w_offset;
            o_result.payload_length = w_plen;
            if (w_plen < i_cfg.min_payload || w_plen > i_cfg.max_payload) begin
                o_result.verdict = ufc_pkg::VERDICT_LENDROP;
            end else if (i_cfg.discard_mode) begin
                o_result.verdict = ufc_pkg::VERDICT_NULLSINK;
            end else if (i_sink_full) begin
                o_result.verdict = ufc_pkg::VERDICT_FULL;
            end else begin
                o_result.verdict = ufc_pkg::VERDICT_ACCEPT;
            end
        end
    end

endmodule
